// ===== rtl/polyline_nearest_segment_search_top_assert.svh =====
// assertion macros used by the polyline search sequencer
`ifndef POLYLINE_NEAREST_SEGMENT_SEARCH_TOP_ASSERT_SVH
`define POLYLINE_NEAREST_SEGMENT_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PNSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnss assertion failed");

// next-cycle implication, disabled during reset
`define PNSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnss assertion failed");

`endif

// ===== rtl/pnss_pkg.sv =====
// types and constants of the polyline nearest segment search block
package pnss_pkg;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam int DIV_STEPS  = 16;
    localparam int SQRT_STEPS = 26;
    localparam int MAC_LAST   = 3;

    localparam logic [47:0] SPACING_SQ_RESET = 48'd65536;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic               found;
        logic        [9:0]  nearest_segment;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] start_z;
        logic        [31:0] path_length;
        logic        [10:0] point_count;
    } rsp_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_CAPTURE, DP_RD_LAST, DP_RD_FIRST, DP_LOAD_E, DP_LOAD_A, DP_LOAD_SEG,
        DP_MAC, DP_CLASSIFY, DP_DIV, DP_SQRT_INIT, DP_SQRT, DP_APPEND, DP_CMP_NEXT,
        DP_CLEAR, DP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_DD, SEL_WD, SEL_DT, SEL_CQ
    } mul_sel_t;

    typedef struct packed {
        dp_op_t     op;
        mul_sel_t   sel;
        logic [4:0] step;
        logic       res_acc;
        logic       res_found;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       cnt_zero;
        logic       cnt_ge2;
        logic       too_near;
        logic       end_point;
        logic       more;
    } status_t;

endpackage

// ===== rtl/polyline_nearest_segment_search_top.sv =====
// top level of the polyline nearest segment search block
//
// channels: req (valid/ready) carries one word per item: mode and a Q15.8
// point. mode add appends the point if spacing allows, query finds the
// nearest segment, clear empties the path, the fourth code only reports.
// rsp (valid/ready) returns exactly one word per item. cfg (valid/ready,
// always ready) writes min_spacing; its square is kept for the test.
// work per item: clear, report, full store or query with under two points
// go straight to the output step; add writes the first point at once,
// stops after the distance pass when too near, and when appending runs
// the 26-step bit-serial square root of the new segment length; query
// runs per stored segment the shared multiplier (four passes: dd, w.d, d*t,
// distance) and the 16-step restoring divider for t, skipping the divider
// and the d*t pass when the closest point clamps to an end.
// one item at a time; the result word shows up together with req_ready,
// so the next item is taken while a result waits.
// reset: the point count and length clear at once, min_spacing returns to
// 256; the point store is not cleared, only written entries are read.
// stall: a result held by a stalled receiver blocks the next result only;
// the block waits in its final step until the output register frees.
module polyline_nearest_segment_search_top #(
    parameter int MAX_POINTS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pnss_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pnss_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [23:0]    cfg_data
);

    pnss_pkg::cmd_t    cmd;
    pnss_pkg::status_t status;

    // spacing writes are taken in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: one state per step of the add or query walk
    pnss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // store, arithmetic and output word
    pnss_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/pnss_ctrl.sv =====
// sequencer for add, query and clear items
`include "polyline_nearest_segment_search_top_assert.svh"

module pnss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  pnss_pkg::status_t status,
    output pnss_pkg::cmd_t    cmd
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_DEC    = 20'h00002,
        ST_A_LD   = 20'h00004,
        ST_A_SQ   = 20'h00008,
        ST_A_CMP  = 20'h00010,
        ST_A_SQRT = 20'h00020,
        ST_A_WR   = 20'h00040,
        ST_Q_RD1  = 20'h00080,
        ST_Q_LDB  = 20'h00100,
        ST_Q_DD   = 20'h00200,
        ST_Q_WD   = 20'h00400,
        ST_Q_CLS  = 20'h00800,
        ST_Q_DIV  = 20'h01000,
        ST_Q_DT   = 20'h02000,
        ST_Q_DIST = 20'h04000,
        ST_Q_CMP  = 20'h08000,
        ST_FIN    = 20'h10000,
        ST_SPARE0 = 20'h20000,
        ST_SPARE1 = 20'h40000,
        ST_SPARE2 = 20'h80000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       acc_flag_reg, acc_flag_next;
    logic       found_flag_reg, found_flag_next;
    logic       out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        acc_flag_next   = acc_flag_reg;
        found_flag_next = found_flag_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        cmd.op          = pnss_pkg::DP_NOP;
        cmd.sel         = pnss_pkg::SEL_DD;
        cmd.step        = step_reg;
        cmd.res_acc     = acc_flag_reg;
        cmd.res_found   = found_flag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op          = pnss_pkg::DP_CAPTURE;
                    acc_flag_next   = 1'b0;
                    found_flag_next = 1'b0;
                    state_next      = ST_DEC;
                end
            end
            ST_DEC:
            begin
                case (status.mode)
                    pnss_pkg::MODE_ADD:
                    begin
                        if (status.full)
                            state_next = ST_FIN;
                        else if (status.cnt_zero)
                            state_next = ST_A_WR;
                        else
                        begin
                            cmd.op     = pnss_pkg::DP_RD_LAST;
                            state_next = ST_A_LD;
                        end
                    end
                    pnss_pkg::MODE_QUERY:
                    begin
                        if (status.cnt_ge2)
                        begin
                            cmd.op     = pnss_pkg::DP_RD_FIRST;
                            state_next = ST_Q_RD1;
                        end
                        else
                            state_next = ST_FIN;
                    end
                    pnss_pkg::MODE_CLEAR:
                    begin
                        cmd.op     = pnss_pkg::DP_CLEAR;
                        state_next = ST_FIN;
                    end
                    default:
                        state_next = ST_FIN;
                endcase
            end
            ST_A_LD:
            begin
                cmd.op     = pnss_pkg::DP_LOAD_E;
                step_next  = '0;
                state_next = ST_A_SQ;
            end
            ST_A_SQ:
            begin
                cmd.op  = pnss_pkg::DP_MAC;
                cmd.sel = pnss_pkg::SEL_DD;
                if (step_reg == 5'(pnss_pkg::MAC_LAST))
                begin
                    step_next  = '0;
                    state_next = ST_A_CMP;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_A_CMP:
            begin
                if (status.too_near)
                    state_next = ST_FIN;
                else
                begin
                    cmd.op     = pnss_pkg::DP_SQRT_INIT;
                    step_next  = '0;
                    state_next = ST_A_SQRT;
                end
            end
            ST_A_SQRT:
            begin
                cmd.op = pnss_pkg::DP_SQRT;
                if (step_reg == 5'(pnss_pkg::SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_A_WR;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_A_WR:
            begin
                cmd.op        = pnss_pkg::DP_APPEND;
                acc_flag_next = 1'b1;
                state_next    = ST_FIN;
            end
            ST_Q_RD1:
            begin
                cmd.op     = pnss_pkg::DP_LOAD_A;
                state_next = ST_Q_LDB;
            end
            ST_Q_LDB:
            begin
                cmd.op     = pnss_pkg::DP_LOAD_SEG;
                step_next  = '0;
                state_next = ST_Q_DD;
            end
            ST_Q_DD, ST_Q_WD, ST_Q_DT, ST_Q_DIST:
            begin
                cmd.op = pnss_pkg::DP_MAC;
                case (state_reg)
                    ST_Q_DD:   cmd.sel = pnss_pkg::SEL_DD;
                    ST_Q_WD:   cmd.sel = pnss_pkg::SEL_WD;
                    ST_Q_DT:   cmd.sel = pnss_pkg::SEL_DT;
                    default:   cmd.sel = pnss_pkg::SEL_CQ;
                endcase
                if (step_reg == 5'(pnss_pkg::MAC_LAST))
                begin
                    step_next = '0;
                    case (state_reg)
                        ST_Q_DD:   state_next = ST_Q_WD;
                        ST_Q_WD:   state_next = ST_Q_CLS;
                        ST_Q_DT:   state_next = ST_Q_DIST;
                        default:   state_next = ST_Q_CMP;
                    endcase
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_Q_CLS:
            begin
                cmd.op     = pnss_pkg::DP_CLASSIFY;
                step_next  = '0;
                state_next = status.end_point ? ST_Q_DIST : ST_Q_DIV;
            end
            ST_Q_DIV:
            begin
                cmd.op = pnss_pkg::DP_DIV;
                if (step_reg == 5'(pnss_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_Q_DT;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_Q_CMP:
            begin
                cmd.op = pnss_pkg::DP_CMP_NEXT;
                if (!status.more)
                begin
                    found_flag_next = 1'b1;
                    state_next      = ST_FIN;
                end
                else
                    state_next = ST_Q_LDB;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.op         = pnss_pkg::DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            acc_flag_reg   <= 1'b0;
            found_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            acc_flag_reg   <= acc_flag_next;
            found_flag_reg <= found_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `PNSS_ASSERT_NEXT(a_accept_decodes, req_valid && req_ready, state_reg == ST_DEC)
    `PNSS_ASSERT_NEXT(a_stall_holds, state_reg == ST_FIN && out_valid_reg && !rsp_ready, state_reg == ST_FIN && out_valid_reg)
    `PNSS_ASSERT_NEXT(a_div_length, state_reg == ST_Q_DIV && step_reg == 5'(pnss_pkg::DIV_STEPS - 1), state_reg == ST_Q_DT)
    `PNSS_ASSERT_NEXT(a_result_shown, state_reg == ST_FIN && (!out_valid_reg || rsp_ready), out_valid_reg && state_reg == ST_IDLE)

endmodule

// ===== rtl/pnss_dp.sv =====
// point store, shared multiplier, divider, square root and result register
module pnss_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pnss_pkg::req_t    req,
    input  logic              cfg_valid,
    input  logic [23:0]       cfg_data,
    input  pnss_pkg::cmd_t    cmd,
    output pnss_pkg::status_t status,
    output pnss_pkg::rsp_t    rsp
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [71:0] mem [MAX_POINTS];
    logic [71:0] rd_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;

    pnss_pkg::req_t     q_reg, q_next;
    pnss_pkg::rsp_t     rsp_reg, rsp_next;
    logic signed [23:0] a_reg [3], a_next [3];
    logic signed [23:0] b_reg [3], b_next [3];
    logic signed [24:0] d_reg [3], d_next [3];
    logic signed [24:0] w_reg [3], w_next [3];
    logic signed [24:0] c_reg [3], c_next [3];
    logic signed [23:0] best_a_reg [3], best_a_next [3];
    logic signed [51:0] prod_reg, prod_next;
    logic signed [53:0] acc_reg, acc_next;
    logic [51:0]        dd_reg, dd_next;
    logic signed [51:0] wd_reg, wd_next;
    logic [53:0]        dist_reg, dist_next;
    logic [53:0]        best_d_reg, best_d_next;
    logic [AW-1:0]      best_i_reg, best_i_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [52:0]        rem_reg, rem_next;
    logic [15:0]        t_reg, t_next;
    logic [51:0]        sq_n_reg, sq_n_next;
    logic [51:0]        sq_res_reg, sq_res_next;
    logic [51:0]        sq_bit_reg, sq_bit_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [31:0]        len_reg, len_next;
    logic [47:0]        spsq_reg, spsq_next;

    logic signed [23:0] qv [3];
    logic signed [23:0] rdv [3];
    logic [CW-1:0]      cnt_m1, i_plus2;
    logic               wd_ge_dd, end_pt;

    assign qv[0]  = q_reg.coord_x;
    assign qv[1]  = q_reg.coord_y;
    assign qv[2]  = q_reg.coord_z;
    assign rdv[0] = rd_reg[71:48];
    assign rdv[1] = rd_reg[47:24];
    assign rdv[2] = rd_reg[23:0];

    assign cnt_m1   = count_reg - CW'(1);
    assign i_plus2  = CW'(i_reg) + CW'(2);
    assign wd_ge_dd = !wd_reg[51] && (wd_reg[51:0] >= dd_reg);
    assign end_pt   = (dd_reg == '0) || wd_reg[51] || (wd_reg == '0) || wd_ge_dd;

    assign status.mode      = q_reg.mode;
    assign status.full      = (count_reg == CW'(MAX_POINTS));
    assign status.cnt_zero  = (count_reg == '0);
    assign status.cnt_ge2   = (count_reg >= CW'(2));
    assign status.too_near  = (dd_reg < {4'b0, spsq_reg});
    assign status.end_point = end_pt;
    assign status.more      = (i_plus2 < count_reg);
    assign rsp = rsp_reg;

    always_comb
    begin
        logic [1:0]         k;
        logic [1:0]         j;
        logic signed [25:0] ma, mb;
        logic signed [25:0] cq;
        logic signed [53:0] acc_base, acc_sum;
        logic signed [51:0] rnd;
        logic [52:0]        rem2;
        logic               ge;
        logic [51:0]        sq_sum;
        logic [32:0]        len_sum;
        logic               better;

        q_next      = q_reg;
        rsp_next    = rsp_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        w_next      = w_reg;
        c_next      = c_reg;
        best_a_next = best_a_reg;
        acc_next    = acc_reg;
        dd_next     = dd_reg;
        wd_next     = wd_reg;
        dist_next   = dist_reg;
        best_d_next = best_d_reg;
        best_i_next = best_i_reg;
        i_next      = i_reg;
        rem_next    = rem_reg;
        t_next      = t_reg;
        sq_n_next   = sq_n_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        spsq_next   = spsq_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];

        // shared multiplier operand select
        k  = cmd.step[1:0];
        j  = cmd.step[1:0] - 2'd1;
        ma = '0;
        mb = '0;
        cq = '0;
        if (cmd.op == pnss_pkg::DP_MAC && k != 2'd3)
        begin
            case (cmd.sel)
                pnss_pkg::SEL_DD:
                begin
                    ma = {d_reg[k][24], d_reg[k]};
                    mb = {d_reg[k][24], d_reg[k]};
                end
                pnss_pkg::SEL_WD:
                begin
                    ma = {w_reg[k][24], w_reg[k]};
                    mb = {d_reg[k][24], d_reg[k]};
                end
                pnss_pkg::SEL_DT:
                begin
                    ma = {d_reg[k][24], d_reg[k]};
                    mb = {10'b0, t_reg};
                end
                default:
                begin
                    cq = {c_reg[k][24], c_reg[k]} - {{2{qv[k][23]}}, qv[k]};
                    ma = cq;
                    mb = cq;
                end
            endcase
        end
        prod_next = ma * mb;

        acc_base = (cmd.step == 5'd1) ? '0 : acc_reg;
        acc_sum  = acc_base + {{2{prod_reg[51]}}, prod_reg};
        rnd      = (prod_reg + 52'sd32768) >>> 16;

        rem2   = {rem_reg[51:0], 1'b0};
        ge     = (rem2 >= {1'b0, dd_reg});
        sq_sum = sq_res_reg + sq_bit_reg;

        len_sum = {1'b0, len_reg} + {7'b0, sq_res_reg[25:0]};
        better  = (i_reg == '0) || (dist_reg < best_d_reg);

        if (cfg_valid)
            spsq_next = cfg_data * cfg_data;

        case (cmd.op)
            pnss_pkg::DP_CAPTURE:
                q_next = req;
            pnss_pkg::DP_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
            end
            pnss_pkg::DP_RD_FIRST:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
                i_next  = '0;
            end
            pnss_pkg::DP_LOAD_E:
            begin
                for (int n = 0; n < 3; n++)
                    d_next[n] = {rdv[n][23], rdv[n]} - {qv[n][23], qv[n]};
            end
            pnss_pkg::DP_LOAD_A:
            begin
                a_next  = rdv;
                rd_en   = 1'b1;
                rd_addr = AW'(1);
            end
            pnss_pkg::DP_LOAD_SEG:
            begin
                b_next = rdv;
                for (int n = 0; n < 3; n++)
                begin
                    d_next[n] = {rdv[n][23], rdv[n]} - {a_reg[n][23], a_reg[n]};
                    w_next[n] = {qv[n][23], qv[n]} - {a_reg[n][23], a_reg[n]};
                end
            end
            pnss_pkg::DP_MAC:
            begin
                if (cmd.step != 5'd0)
                begin
                    acc_next = acc_sum;
                    if (cmd.sel == pnss_pkg::SEL_DT)
                        c_next[j] = {a_reg[j][23], a_reg[j]} + rnd[24:0];
                    if (cmd.step == 5'(pnss_pkg::MAC_LAST))
                    begin
                        case (cmd.sel)
                            pnss_pkg::SEL_DD: dd_next   = acc_sum[51:0];
                            pnss_pkg::SEL_WD: wd_next   = acc_sum[51:0];
                            pnss_pkg::SEL_CQ: dist_next = acc_sum;
                            default:          dist_next = dist_reg;
                        endcase
                    end
                end
            end
            pnss_pkg::DP_CLASSIFY:
            begin
                if ((dd_reg == '0) || wd_reg[51] || (wd_reg == '0))
                begin
                    for (int n = 0; n < 3; n++)
                        c_next[n] = {a_reg[n][23], a_reg[n]};
                end
                else if (wd_ge_dd)
                begin
                    for (int n = 0; n < 3; n++)
                        c_next[n] = {b_reg[n][23], b_reg[n]};
                end
                else
                begin
                    rem_next = {1'b0, wd_reg};
                    t_next   = '0;
                end
            end
            pnss_pkg::DP_DIV:
            begin
                rem_next = ge ? (rem2 - {1'b0, dd_reg}) : rem2;
                t_next   = {t_reg[14:0], ge};
            end
            pnss_pkg::DP_SQRT_INIT:
            begin
                sq_n_next   = dd_reg;
                sq_res_next = '0;
                sq_bit_next = 52'd1 << 50;
            end
            pnss_pkg::DP_SQRT:
            begin
                if (sq_n_reg >= sq_sum)
                begin
                    sq_n_next   = sq_n_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
            end
            pnss_pkg::DP_APPEND:
            begin
                if (count_reg != '0)
                    len_next = len_sum[32] ? '1 : len_sum[31:0];
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
            end
            pnss_pkg::DP_CMP_NEXT:
            begin
                if (better)
                begin
                    best_d_next = dist_reg;
                    best_i_next = i_reg;
                    best_a_next = a_reg;
                end
                if (i_plus2 < count_reg)
                begin
                    a_next  = b_reg;
                    i_next  = i_reg + AW'(1);
                    rd_en   = 1'b1;
                    rd_addr = i_plus2[AW-1:0];
                end
            end
            pnss_pkg::DP_CLEAR:
            begin
                count_next = '0;
                len_next   = '0;
            end
            pnss_pkg::DP_OUT:
            begin
                rsp_next.accepted        = cmd.res_acc;
                rsp_next.found           = cmd.res_found;
                rsp_next.nearest_segment = cmd.res_found ? 10'(best_i_reg) : 10'd0;
                rsp_next.start_x         = cmd.res_found ? best_a_reg[0] : 24'sd0;
                rsp_next.start_y         = cmd.res_found ? best_a_reg[1] : 24'sd0;
                rsp_next.start_z         = cmd.res_found ? best_a_reg[2] : 24'sd0;
                rsp_next.path_length     = len_reg;
                rsp_next.point_count     = 11'(count_reg);
            end
            default:
                q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {q_reg.coord_x, q_reg.coord_y, q_reg.coord_z};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= '0;
            spsq_reg  <= pnss_pkg::SPACING_SQ_RESET;
        end
        else
        begin
            count_reg <= count_next;
            len_reg   <= len_next;
            spsq_reg  <= spsq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        rsp_reg    <= rsp_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        d_reg      <= d_next;
        w_reg      <= w_next;
        c_reg      <= c_next;
        best_a_reg <= best_a_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        dd_reg     <= dd_next;
        wd_reg     <= wd_next;
        dist_reg   <= dist_next;
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        i_reg      <= i_next;
        rem_reg    <= rem_next;
        t_reg      <= t_next;
        sq_n_reg   <= sq_n_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
    end

endmodule

// ===== bench/tb_polyline_nearest_segment_search_top.sv =====
// testbench for the polyline nearest segment search block
`timescale 1ns / 1ps

module tb_polyline_nearest_segment_search_top;

    // the fourth mode code only reports length and count
    localparam logic [1:0] MODE_REPORT = 2'd3;
    localparam int STORE_DEPTH = 1024;
    localparam int FILL_POINTS = 170;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic signed [23:0] C_MAX = 24'sh7fffff;
    localparam logic signed [23:0] C_MIN = 24'sh800000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    pnss_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    pnss_pkg::rsp_t rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [23:0]    cfg_data;

    polyline_nearest_segment_search_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow copy of the path held by the block
    logic signed [23:0] path_x [STORE_DEPTH];
    logic signed [23:0] path_y [STORE_DEPTH];
    logic signed [23:0] path_z [STORE_DEPTH];
    int unsigned        path_count;
    logic [31:0]        path_len;
    logic [23:0]        spacing;

    pnss_pkg::rsp_t pending_rsp [$];
    int   mismatches;
    int   words_in;
    int   words_out;
    int   queries_found;
    int   adds_refused;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // squared distance from the query point to the clamped closest point of segment i
    function automatic longint seg_dist_sq(int unsigned i, longint qx, longint qy, longint qz);
        longint ax, ay, az, dx, dy, dz, wx, wy, wz, dd, wd, cx, cy, cz, rem, t;
        ax = path_x[i];
        ay = path_y[i];
        az = path_z[i];
        dx = longint'(path_x[i + 1]) - ax;
        dy = longint'(path_y[i + 1]) - ay;
        dz = longint'(path_z[i + 1]) - az;
        wx = qx - ax;
        wy = qy - ay;
        wz = qz - az;
        dd = dx * dx + dy * dy + dz * dz;
        wd = wx * dx + wy * dy + wz * dz;
        if (dd == 0 || wd <= 0)
        begin
            cx = ax; cy = ay; cz = az;
        end
        else if (wd >= dd)
        begin
            cx = ax + dx; cy = ay + dy; cz = az + dz;
        end
        else
        begin
            // 16 bit restoring division for the fraction along the segment
            rem = wd;
            t   = 0;
            for (int k = 0; k < 16; k++)
            begin
                rem = rem <<< 1;
                t   = t <<< 1;
                if (rem >= dd)
                begin
                    rem = rem - dd;
                    t   = t | 1;
                end
            end
            cx = ax + ((dx * t + 32768) >>> 16);
            cy = ay + ((dy * t + 32768) >>> 16);
            cz = az + ((dz * t + 32768) >>> 16);
        end
        return (cx - qx) * (cx - qx) + (cy - qy) * (cy - qy) + (cz - qz) * (cz - qz);
    endfunction

    // next word of the result stream for one request, updating the shadow path
    function automatic pnss_pkg::rsp_t path_step(pnss_pkg::req_t r);
        pnss_pkg::rsp_t  o;
        longint          x, y, z, d2, sp, bestd, d;
        longint unsigned sum;
        int unsigned     best, l;
        o = '0;
        x = r.coord_x;
        y = r.coord_y;
        z = r.coord_z;
        case (r.mode)
            pnss_pkg::MODE_ADD:
            begin
                if (path_count < STORE_DEPTH)
                begin
                    d2 = 0;
                    sp = longint'(spacing);
                    if (path_count > 0)
                    begin
                        l  = path_count - 1;
                        d2 = (path_x[l] - x) * (path_x[l] - x) + (path_y[l] - y) * (path_y[l] - y)
                             + (path_z[l] - z) * (path_z[l] - z);
                    end
                    if (path_count == 0 || d2 >= sp * sp)
                    begin
                        if (path_count > 0)
                        begin
                            sum = longint'(path_len) + int_sqrt(d2);
                            path_len = (sum > 64'hffffffff) ? 32'hffffffff : sum[31:0];
                        end
                        path_x[path_count] = r.coord_x;
                        path_y[path_count] = r.coord_y;
                        path_z[path_count] = r.coord_z;
                        path_count++;
                        o.accepted = 1'b1;
                    end
                end
            end
            pnss_pkg::MODE_QUERY:
            begin
                if (path_count >= 2)
                begin
                    best  = 0;
                    bestd = 0;
                    for (int unsigned i = 0; i + 1 < path_count; i++)
                    begin
                        d = seg_dist_sq(i, x, y, z);
                        // strict compare keeps the first segment on a tie
                        if (i == 0 || d < bestd)
                        begin
                            bestd = d;
                            best  = i;
                        end
                    end
                    o.found           = 1'b1;
                    o.nearest_segment = best[9:0];
                    o.start_x         = path_x[best];
                    o.start_y         = path_y[best];
                    o.start_z         = path_z[best];
                end
            end
            pnss_pkg::MODE_CLEAR:
            begin
                path_count = 0;
                path_len   = '0;
            end
            default: ;
        endcase
        o.path_length = path_len;
        o.point_count = path_count[10:0];
        return o;
    endfunction

    function automatic pnss_pkg::rsp_t fixed_rsp(bit acc, bit fnd, int unsigned cnt,
                                                 logic [31:0] len);
        pnss_pkg::rsp_t o;
        o             = '0;
        o.accepted    = acc;
        o.found       = fnd;
        o.point_count = cnt[10:0];
        o.path_length = len;
        return o;
    endfunction

    function automatic pnss_pkg::req_t mk_req(logic [1:0] m, logic signed [23:0] x,
                                              logic signed [23:0] y, logic signed [23:0] z);
        pnss_pkg::req_t r;
        r.mode    = m;
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        return r;
    endfunction

    // one request word: optional sender gap, then hold until taken
    task automatic send_word(pnss_pkg::req_t r, bit typed, pnss_pkg::rsp_t typed_rsp);
        pnss_pkg::rsp_t e;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        e = path_step(r);
        if (r.mode == pnss_pkg::MODE_ADD && !e.accepted)
            adds_refused++;
        pending_rsp = {pending_rsp, (typed ? typed_rsp : e)};
        words_in++;
    endtask

    task automatic send_predicted(pnss_pkg::req_t r);
        send_word(r, 1'b0, '0);
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(negedge clk);
    endtask

    // register write, only issued while the block is idle
    task automatic write_spacing(logic [23:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        spacing = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        pnss_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            words_out++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", rsp);
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (e.found)
                    queries_found++;
                if (rsp.accepted !== e.accepted || rsp.found !== e.found
                    || rsp.nearest_segment !== e.nearest_segment
                    || rsp.start_x !== e.start_x || rsp.start_y !== e.start_y
                    || rsp.start_z !== e.start_z || rsp.path_length !== e.path_length
                    || rsp.point_count !== e.point_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected acc %b fnd %b seg %0d start %h %h %h",
                                 words_out, e.accepted, e.found, e.nearest_segment,
                                 e.start_x, e.start_y, e.start_z);
                        $display("    len %h cnt %0d, got acc %b fnd %b seg %0d start %h %h %h",
                                 e.path_length, e.point_count, rsp.accepted, rsp.found,
                                 rsp.nearest_segment, rsp.start_x, rsp.start_y, rsp.start_z);
                        $display("    got len %h cnt %0d", rsp.path_length, rsp.point_count);
                    end
                end
            end
        end
    end

    // receiver back pressure
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending_rsp.size());
            $display("Mismatches found");
            $finish;
        end
    end

    typedef struct {
        bit             is_cfg;
        logic [23:0]    cfg_val;
        pnss_pkg::req_t r;
        bit             typed;
        pnss_pkg::rsp_t e;
    } dir_row_t;

    dir_row_t dir_rows [$];

    task automatic row_req(pnss_pkg::req_t r, bit typed, pnss_pkg::rsp_t e);
        dir_row_t d;
        d.is_cfg  = 1'b0;
        d.cfg_val = '0;
        d.r       = r;
        d.typed   = typed;
        d.e       = e;
        dir_rows  = {dir_rows, d};
    endtask

    task automatic row_cfg(logic [23:0] v);
        dir_row_t d;
        d.is_cfg  = 1'b1;
        d.cfg_val = v;
        d.r       = '0;
        d.typed   = 1'b0;
        d.e       = '0;
        dir_rows  = {dir_rows, d};
    endtask

    function automatic logic signed [23:0] rand_full();
        return 24'($urandom());
    endfunction

    function automatic logic signed [23:0] near(logic signed [23:0] c, int span);
        return 24'(c + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // a well-formed path: clear, a few spaced points, then queries around it
    task automatic random_path(int n_pts, int n_q, bit wide);
        logic signed [23:0] cx, cy, cz;
        int                 span;
        span = wide ? 4194304 : (int'(spacing) * 3 + 64);
        send_predicted(mk_req(pnss_pkg::MODE_CLEAR, rand_full(), rand_full(), rand_full()));
        cx = wide ? rand_full() : 24'($signed($urandom_range(0, 65535)) - 32768);
        cy = wide ? rand_full() : 24'($signed($urandom_range(0, 65535)) - 32768);
        cz = wide ? rand_full() : 24'($signed($urandom_range(0, 65535)) - 32768);
        for (int i = 0; i < n_pts; i++)
        begin
            send_predicted(mk_req(pnss_pkg::MODE_ADD, cx, cy, cz));
            cx = near(cx, span);
            cy = near(cy, span);
            cz = near(cz, span);
        end
        for (int i = 0; i < n_q; i++)
            send_predicted(mk_req(pnss_pkg::MODE_QUERY, near(cx, span * 2),
                                  near(cy, span * 2), near(cz, span * 2)));
    endtask

    task automatic random_phase(int items);
        int start;
        int pick;
        start = words_in;
        while (words_in - start < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_predicted(mk_req(MODE_REPORT, rand_full(), rand_full(), rand_full()));
            else if (pick < 15)
                // noise: any mode, any point, on whatever path is held
                send_predicted(mk_req(2'($urandom_range(0, 3)), rand_full(), rand_full(),
                                      rand_full()));
            else
                random_path($urandom_range(0, 10), $urandom_range(1, 4), pick < 30);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        words_in       = 0;
        words_out      = 0;
        queries_found  = 0;
        adds_refused   = 0;
        idle_cycles    = 0;
        path_count     = 0;
        path_len       = '0;
        spacing        = 24'd256;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: empty path, extremes, refusals, zero spacing, repeats
        row_req(mk_req(pnss_pkg::MODE_QUERY, '0, '0, '0), 1'b1, fixed_rsp(0, 0, 0, 0));
        row_req(mk_req(MODE_REPORT, C_MAX, C_MIN, C_MAX), 1'b1, fixed_rsp(0, 0, 0, 0));
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MAX, C_MAX, C_MAX), 1'b1, fixed_rsp(1, 0, 1, 0));
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MAX, C_MAX, C_MAX), 1'b1, fixed_rsp(0, 0, 1, 0));
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MIN, C_MIN, C_MIN), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_QUERY, '0, '0, '0), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_ADD, '0, '0, '0), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_ADD, '0, '0, 24'sd1), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_QUERY, C_MAX, C_MIN, '0), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_QUERY, C_MIN, C_MIN, C_MIN), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_CLEAR, C_MIN, C_MAX, '0), 1'b1, fixed_rsp(0, 0, 0, 0));
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MIN, C_MAX, C_MIN), 1'b1, fixed_rsp(1, 0, 1, 0));
        row_req(mk_req(pnss_pkg::MODE_QUERY, C_MAX, C_MAX, C_MAX), 1'b1, fixed_rsp(0, 0, 1, 0));
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MAX, C_MIN, C_MAX), 1'b0, '0);
        row_cfg(24'd0);
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MAX, C_MIN, C_MAX), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_QUERY, C_MAX, C_MIN, C_MAX), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_QUERY, '0, '0, '0), 1'b0, '0);
        row_req(mk_req(MODE_REPORT, '0, '0, '0), 1'b0, '0);
        row_cfg(24'hffffff);
        row_req(mk_req(pnss_pkg::MODE_ADD, '0, '0, '0), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_ADD, C_MIN, C_MAX, C_MIN), 1'b0, '0);
        row_req(mk_req(pnss_pkg::MODE_CLEAR, '0, '0, '0), 1'b1, fixed_rsp(0, 0, 0, 0));
        row_cfg(24'd256);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_spacing(dir_rows[i].cfg_val);
            else
                send_word(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
        end

        // random phases, each with its own idling mix and spacing
        random_phase(75);
        write_spacing($urandom_range(1, 1024));
        send_idle_pct = 53;
        random_phase(75);
        write_spacing(24'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        random_phase(75);

        // hop between opposite corners so the running length saturates
        send_predicted(mk_req(pnss_pkg::MODE_CLEAR, '0, '0, '0));
        for (int i = 0; i < FILL_POINTS; i++)
        begin
            if (i % 2 == 0)
                send_predicted(mk_req(pnss_pkg::MODE_ADD, 24'(C_MAX - $urandom_range(0, 255)),
                                      24'(C_MAX - $urandom_range(0, 255)), C_MAX));
            else
                send_predicted(mk_req(pnss_pkg::MODE_ADD, 24'(C_MIN + $urandom_range(0, 255)),
                                      24'(C_MIN + $urandom_range(0, 255)), C_MIN));
        end
        // sender holds off until the block has caught up
        drain();
        send_predicted(mk_req(pnss_pkg::MODE_QUERY, rand_full(), rand_full(), rand_full()));
        send_predicted(mk_req(MODE_REPORT, '0, '0, '0));

        write_spacing(24'hffffff);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        random_phase(55);
        write_spacing(24'd256);
        random_phase(80);

        drain();
        repeat (100) @(posedge clk);
        $display("%0d request words sent and %0d result words checked, %0d adds refused",
                 words_in, words_out, adds_refused);
        $display("%0d queries found a segment; spacing 0, 256, random and full scale used",
                 queries_found);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
